>>> src/seven_segment_scan_driver_assert.svh
// Assertion macros shared by the checker of the seven-segment scan driver.
// Depends on nothing; the including file supplies clock, reset and signals.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH

// Property checked at every rising edge, switched off while reset is high.
`define SSD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define SSD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ssd_pkg.sv
// Package of the seven-segment scan driver: word types, codes, segment glyphs.
// Depends on nothing; used by every module of the block except ssd_fifo.
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  localparam int DIGIT_COUNT      = 4;
  localparam int POS_WIDTH        = $clog2(DIGIT_COUNT);
  localparam int TENTHS_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // floor(x / 10) == (x * DIV10_MULT) >> DIV10_SHIFT holds for every x below 2**22.
  localparam int DIV10_SHIFT      = 23;
  localparam int DIV10_MULT_WIDTH = 20;
  localparam logic [DIV10_MULT_WIDTH-1:0] DIV10_MULT = DIV10_MULT_WIDTH'(838861);

  typedef enum logic [1:0] {
    REQ_NUMBER = 2'd0,
    REQ_SYMBOL = 2'd1,
    REQ_TICK   = 2'd2
  } req_t;

  localparam logic [3:0] SYM_CM          = 4'd1;
  localparam logic [3:0] SYM_INCH        = 4'd2;
  localparam logic [3:0] SYM_DOT         = 4'd3;
  localparam logic [3:0] SYM_EIGHT_FIRST = 4'd5;
  localparam logic [3:0] SYM_EIGHT_LAST  = 4'd8;

  // Active-high segment patterns, bit 6 is a and bit 0 is g.
  localparam logic [6:0] SEG_BLANK = 7'h00;
  localparam logic [6:0] SEG_EIGHT = 7'h7F;
  localparam logic [6:0] SEG_UC_C  = 7'h4E;
  localparam logic [6:0] SEG_UC_E  = 7'h4F;
  localparam logic [6:0] SEG_UC_N  = 7'h76;
  localparam logic [6:0] SEG_LC_T  = 7'h0F;
  localparam logic [6:0] SEG_LC_I  = 7'h10;
  localparam logic [6:0] SEG_LC_N  = 7'h15;
  localparam logic [6:0] SEG_LC_C  = 7'h0D;
  localparam logic [6:0] SEG_LC_H  = 7'h17;

  typedef logic [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] tenths;
    logic [3:0]  symbol;
  } in_word_t;

  typedef struct packed {
    logic [DIGIT_COUNT-1:0] digit_enable_n;
    logic [6:0]             segments_n;
    logic                   point_n;
    pos_t                   digit_index;
  } out_word_t;

  // One scan job as classified by the front end.
  typedef struct packed {
    pos_t       pos;
    logic       use_digit;
    logic [6:0] pattern;
    logic       point;
  } job_t;

  function automatic logic [6:0] digit_segments(input logic [3:0] d);
    logic [6:0] seg;
    case (d)
      4'd0:    seg = 7'h7E;
      4'd1:    seg = 7'h30;
      4'd2:    seg = 7'h6D;
      4'd3:    seg = 7'h79;
      4'd4:    seg = 7'h33;
      4'd5:    seg = 7'h5B;
      4'd6:    seg = 7'h5F;
      4'd7:    seg = 7'h70;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h7B;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

>>> src/ssd_fifo.sv
// Small register queue between the front end and the digit pipeline.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ssd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty,
  output logic                  full
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_data = slots[rd_ptr];
  assign empty   = (count == '0);
  assign full    = (count == COUNT_W'(DEPTH));

endmodule

`default_nettype wire

>>> src/ssd_front.sv
// Front end: takes request words, holds the shown item and scan position,
// and turns each tick into a classified scan job. Depends on ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssd_front #(
  parameter int TENTHS_WIDTH = ssd_pkg::TENTHS_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire ssd_pkg::in_word_t       request,
  output logic                         job_push,
  output ssd_pkg::job_t                job,
  output logic      [TENTHS_WIDTH-1:0] value,
  input  wire logic                    job_full
);

  logic [TENTHS_WIDTH-1:0] shown_tenths;
  logic                    shown_is_symbol;
  logic [3:0]              shown_symbol;
  ssd_pkg::pos_t           scan_position;
  ssd_pkg::pos_t           pos_next;
  logic                    accept;
  logic                    is_zero;
  logic                    ge_hundred;
  logic                    ge_thousand;

  assign full     = job_full;
  assign accept   = push && !job_full;
  assign job_push = accept && (request.req_type == ssd_pkg::REQ_TICK);
  assign pos_next = scan_position + 1'b1;
  assign value    = shown_tenths;

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_tenths    <= '0;
      shown_is_symbol <= 1'b0;
      shown_symbol    <= '0;
      scan_position   <= '0;
    end else if (accept) begin
      case (request.req_type)
        ssd_pkg::REQ_NUMBER: begin
          shown_tenths    <= TENTHS_WIDTH'(request.tenths);
          shown_is_symbol <= 1'b0;
        end
        ssd_pkg::REQ_SYMBOL: begin
          shown_symbol    <= request.symbol;
          shown_is_symbol <= 1'b1;
        end
        ssd_pkg::REQ_TICK: begin
          scan_position <= pos_next;
        end
        default: begin
        end
      endcase
    end
  end

  assign is_zero     = (shown_tenths == '0);
  assign ge_hundred  = (shown_tenths >= TENTHS_WIDTH'(100));
  assign ge_thousand = (shown_tenths >= TENTHS_WIDTH'(1000));

  always_comb begin
    job.pos       = pos_next;
    job.use_digit = 1'b0;
    job.pattern   = ssd_pkg::SEG_BLANK;
    job.point     = 1'b0;
    if (!shown_is_symbol) begin
      // Leading digits are blanked below 100 and 1000, except for plain zero.
      job.use_digit = !((pos_next == 2'd1 && !ge_hundred && !is_zero) ||
                        (pos_next == 2'd0 && !ge_thousand && !is_zero));
      job.point     = is_zero ? (pos_next == 2'd3) : (pos_next == 2'd2);
    end else begin
      case (shown_symbol)
        ssd_pkg::SYM_CM: begin
          case (pos_next)
            2'd0:    job.pattern = ssd_pkg::SEG_UC_C;
            2'd1:    job.pattern = ssd_pkg::SEG_UC_E;
            2'd2:    job.pattern = ssd_pkg::SEG_UC_N;
            default: job.pattern = ssd_pkg::SEG_LC_T;
          endcase
        end
        ssd_pkg::SYM_INCH: begin
          case (pos_next)
            2'd0:    job.pattern = ssd_pkg::SEG_LC_I;
            2'd1:    job.pattern = ssd_pkg::SEG_LC_N;
            2'd2:    job.pattern = ssd_pkg::SEG_LC_C;
            default: job.pattern = ssd_pkg::SEG_LC_H;
          endcase
        end
        ssd_pkg::SYM_DOT: begin
          job.point = (pos_next == 2'd2);
        end
        default: begin
          if (shown_symbol inside {[ssd_pkg::SYM_EIGHT_FIRST:ssd_pkg::SYM_EIGHT_LAST]} &&
              pos_next == 2'(shown_symbol - ssd_pkg::SYM_EIGHT_FIRST)) begin
            job.pattern = ssd_pkg::SEG_EIGHT;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/ssd_back.sv
// Back end: a pipeline that extracts the decimal digit of a scan job by
// repeated division by ten and drives the output register. Depends on ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssd_back #(
  parameter int TENTHS_WIDTH = ssd_pkg::TENTHS_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ssd_pkg::job_t           job,
  input  wire logic [TENTHS_WIDTH-1:0] value,
  input  wire logic                    job_empty,
  output logic                         job_pop,
  output ssd_pkg::out_word_t           result,
  output logic                         empty,
  input  wire logic                    pop
);

  localparam int PROD_W = TENTHS_WIDTH + ssd_pkg::DIV10_MULT_WIDTH;

  function automatic logic [TENTHS_WIDTH-1:0] div10(input logic [TENTHS_WIDTH-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(ssd_pkg::DIV10_MULT);
    return TENTHS_WIDTH'(prod >> ssd_pkg::DIV10_SHIFT);
  endfunction

  logic                    a_valid, b_valid, c_valid, d_valid, out_valid;
  ssd_pkg::job_t           a_job, b_job, c_job, d_job;
  logic [TENTHS_WIDTH-1:0] a_val, b_val, c_val, d_val, d_quot;
  logic                    a_ready, b_ready, c_ready, d_ready, out_ready;
  logic [TENTHS_WIDTH-1:0] remainder;
  logic [6:0]              pattern;

  assign out_ready = !out_valid || pop;
  assign d_ready   = !d_valid || out_ready;
  assign c_ready   = !c_valid || d_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign job_pop   = !job_empty && a_ready;
  assign empty     = !out_valid;

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= job_pop;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
      if (d_ready) begin
        d_valid <= c_valid;
      end
      if (out_ready) begin
        out_valid <= d_valid;
      end
    end
  end

  // Position p needs the value divided by ten 3 - p times before the last digit is taken.
  assign remainder = d_val - ((d_quot << 3) + (d_quot << 1));
  assign pattern   = d_job.use_digit ? ssd_pkg::digit_segments(remainder[3:0]) : d_job.pattern;

  always_ff @(posedge clk) begin
    if (job_pop) begin
      a_job <= job;
      a_val <= (job.pos != 2'd3) ? div10(value) : value;
    end
    if (a_valid && b_ready) begin
      b_job <= a_job;
      b_val <= (a_job.pos == 2'd0 || a_job.pos == 2'd1) ? div10(a_val) : a_val;
    end
    if (b_valid && c_ready) begin
      c_job <= b_job;
      c_val <= (b_job.pos == 2'd0) ? div10(b_val) : b_val;
    end
    if (c_valid && d_ready) begin
      d_job  <= c_job;
      d_val  <= c_val;
      d_quot <= div10(c_val);
    end
    if (d_valid && out_ready) begin
      result.digit_enable_n <= ~(ssd_pkg::DIGIT_COUNT'(1) << d_job.pos);
      result.segments_n     <= ~pattern;
      result.point_n        <= ~d_job.point;
      result.digit_index    <= d_job.pos;
    end
  end

endmodule

`default_nettype wire

>>> src/seven_segment_scan_driver.sv
// Top level of the four-digit seven-segment scan driver.
// Depends on ssd_pkg, ssd_front, ssd_fifo and ssd_back.
//
// Request channel: a word is taken on a rising edge with push high and full
// low. A number word latches a value in tenths, a symbol word latches a
// symbol code; neither gives a result. A tick word steps the scan position
// by one (modulo four) and yields one result word for the new position.
// Result channel: while empty is low the oldest result sits on result, and
// it leaves on a rising edge with pop high.
// Throughput: one word per cycle on both sides while full stays low and
// pop is high; the digit pipeline has one divide-by-ten multiplier per
// stage ahead of the output register and advances every cycle it can.
// Reset (rst, synchronous): the shown number becomes zero in number mode,
// the scan position zero, and the job queue and pipeline are emptied, so the
// first tick after reset drives digit one.
// When pop stays low, the pipeline fills up behind the held result, then the
// job queue, and full rises; show words wait for full to fall too.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_scan_driver #(
  parameter int TENTHS_WIDTH = ssd_pkg::TENTHS_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = ssd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire ssd_pkg::in_word_t  request,
  output logic                    empty,
  input  wire logic               pop,
  output ssd_pkg::out_word_t      result
);

  localparam int JOB_WIDTH = $bits(ssd_pkg::job_t) + TENTHS_WIDTH;

  // Jobs carry the control part as a struct and the latched value beside it.
  ssd_pkg::job_t           front_job;
  logic [TENTHS_WIDTH-1:0] front_value;
  logic                    job_push;
  logic                    job_full;
  ssd_pkg::job_t           back_job;
  logic [TENTHS_WIDTH-1:0] back_value;
  logic [JOB_WIDTH-1:0]    queue_out;
  logic                    job_empty;
  logic                    job_pop;

  ssd_front #(
    .TENTHS_WIDTH(TENTHS_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .job_push (job_push),
    .job      (front_job),
    .value    (front_value),
    .job_full (job_full)
  );

  // The queue lets ticks and show words flow in while results are held.
  ssd_fifo #(
    .WIDTH(JOB_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data ({front_job, front_value}),
    .rd_en   (job_pop),
    .rd_data (queue_out),
    .empty   (job_empty),
    .full    (job_full)
  );

  assign {back_job, back_value} = queue_out;

  ssd_back #(
    .TENTHS_WIDTH(TENTHS_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .value     (back_value),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

>>> src/ssd_checker.sv
// Port-level checker of the seven-segment scan driver, bound to the top level.
// Depends on ssd_pkg and seven_segment_scan_driver_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "seven_segment_scan_driver_assert.svh"

module ssd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire ssd_pkg::out_word_t result
);

  // Index of the last word taken, to follow the scan order.
  logic                            seen;
  ssd_pkg::pos_t                   last_index;
  ssd_pkg::pos_t                   next_index;
  logic [ssd_pkg::DIGIT_COUNT-1:0] index_enable_n;
  logic                            waiting;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      last_index <= '0;
    end else if (pop && !empty) begin
      seen       <= 1'b1;
      last_index <= result.digit_index;
    end
  end

  assign next_index     = ssd_pkg::pos_t'(last_index + 1'b1);
  assign index_enable_n = ~(ssd_pkg::DIGIT_COUNT'(1) << result.digit_index);
  assign waiting        = !empty && !pop;

  `SSD_ASSERT(a_result_held, clk, rst, waiting |=> (!empty && $stable(result)), "result changed")
  `SSD_ASSERT(a_enable_matches_index, clk, rst, !empty |-> (result.digit_enable_n == index_enable_n), "bad enable")
  `SSD_ASSERT(a_scan_order, clk, rst, (!empty && seen) |-> (result.digit_index == next_index), "scan skipped")
  `SSD_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (empty && !full), "reset did not empty the block")

endmodule

bind seven_segment_scan_driver ssd_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .result  (result)
);

`default_nettype wire
